// ===== rtl/rdfd_pkg.sv =====
// Shared types, constants and the gear-to-duty table for the drive frame decoder.
// No dependencies; every rdfd module imports this package.
package rdfd_pkg;

    // frame byte codes
    localparam logic [7:0] HEADER_BYTE   = 8'h01;
    localparam logic [7:0] DIR_FORWARD   = 8'h00;
    localparam logic [7:0] DIR_BACKWARD  = 8'hFF;
    localparam logic [7:0] STEER_LOW     = 8'h00;
    localparam logic [7:0] STEER_HIGH    = 8'hFF;
    localparam logic [7:0] PINS_FORWARD  = 8'h05;
    localparam logic [7:0] PINS_BACKWARD = 8'h00;

    // gear limits
    localparam logic [2:0] GEAR_MIN = 3'd1;
    localparam logic [2:0] GEAR_MAX = 3'd5;

    // position inside a frame
    typedef enum logic [3:0] {
        POS_HEADER  = 4'b0001,
        POS_DIR     = 4'b0010,
        POS_STEER   = 4'b0100,
        POS_BUTTONS = 4'b1000
    } frame_pos_t;

    // state carried from frame to frame
    typedef struct packed {
        logic [7:0] dir_byte;
        logic [7:0] steer_byte;
        logic [2:0] gear;
        logic       up_prev;
        logic       down_prev;
        logic [7:0] pins;
    } drive_state_t;

    // one result word
    typedef struct packed {
        logic [7:0] duty_a;
        logic [7:0] duty_b;
        logic [7:0] pins;
        logic [2:0] gear;
    } drive_result_t;

    // 128 / gear; out-of-range gears repeat the nearest entry
    function automatic logic [7:0] duty_lookup(input logic [2:0] gear);
        logic [7:0] d;
        case (gear)
            3'd0:    d = 8'd128;
            3'd1:    d = 8'd128;
            3'd2:    d = 8'd64;
            3'd3:    d = 8'd42;
            3'd4:    d = 8'd32;
            default: d = 8'd25;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/rdfd_drive_calc.sv =====
// Combinational frame evaluation: duties, direction pins and gear update.
// Depends on rdfd_pkg.
module rdfd_drive_calc
    import rdfd_pkg::*;
(
    input  drive_state_t  state_in,
    input  logic [7:0]    button_byte,
    output drive_result_t result,
    output drive_state_t  state_out
);

    logic [7:0] duty;
    logic       is_fwd;
    logic       is_bwd;
    logic [2:0] gear_up;
    logic [2:0] gear_dn;
    logic       up_now;
    logic       down_now;

    // duties and pins from the stored direction and steering bytes
    always_comb begin
        duty          = duty_lookup(state_in.gear);
        is_fwd        = (state_in.dir_byte == DIR_FORWARD);
        is_bwd        = (state_in.dir_byte == DIR_BACKWARD);
        result.duty_a = '0;
        result.duty_b = '0;
        result.pins   = state_in.pins;
        if (is_fwd || is_bwd) begin
            result.pins = is_fwd ? PINS_FORWARD : PINS_BACKWARD;
            if (state_in.steer_byte == STEER_LOW) begin
                result.duty_a = is_fwd ? 8'd0 : duty;
                result.duty_b = is_fwd ? duty : 8'd0;
            end else if (state_in.steer_byte == STEER_HIGH) begin
                result.duty_a = is_fwd ? duty : 8'd0;
                result.duty_b = is_fwd ? 8'd0 : duty;
            end else begin
                result.duty_a = duty;
                result.duty_b = duty;
            end
        end
        result.gear = gear_dn;
    end

    // gear shifts on button release (active low), up before down
    always_comb begin
        up_now   = ~button_byte[0];
        down_now = ~button_byte[1];
        gear_up  = state_in.gear;
        if (!up_now && state_in.up_prev && (state_in.gear < GEAR_MAX)) begin
            gear_up = state_in.gear + 3'd1;
        end
        gear_dn = gear_up;
        if (!down_now && state_in.down_prev && (gear_up > GEAR_MIN)) begin
            gear_dn = gear_up - 3'd1;
        end
        state_out           = state_in;
        state_out.gear      = gear_dn;
        state_out.up_prev   = up_now;
        state_out.down_prev = down_now;
        state_out.pins      = result.pins;
    end

endmodule

// ===== rtl/remote_drive_frame_decoder_unit.sv =====
// Top level of the drive frame decoder: input word register, frame tracking,
// result register. Depends on rdfd_pkg and rdfd_drive_calc.
//
// Usage:
//   s_valid/s_ready/s_rx_byte carry received serial bytes, one word each.
//   A frame is header 0x01, direction, steering, buttons; bytes seen while
//   waiting for a header are dropped without a result.
//   m_valid/m_ready carry one result word per frame: m_duty_a, m_duty_b,
//   m_direction_pins, m_gear_now.
// Timing:
//   One byte accepted per cycle, sustained while no button byte waits on a
//   stalled result. A byte is held in the input register and is evaluated
//   from there into the result register, so the result of a button byte
//   shows on m_valid once it has passed through both registers.
// Stall:
//   While a result waits on m_ready, header, direction and steering bytes
//   still flow; a button byte waits in the input register and s_ready stays
//   low until the result register frees.
// Reset:
//   aresetn (synchronous, active low) empties both registers, returns to
//   waiting for a header, gear 1, pins 0, buttons released.
module remote_drive_frame_decoder_unit
    import rdfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_duty_a,
    output logic [7:0] m_duty_b,
    output logic [7:0] m_direction_pins,
    output logic [2:0] m_gear_now
);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    frame_pos_t    pos_reg, pos_next;
    drive_state_t  state_reg, state_next;
    logic          m_valid_reg, m_valid_next;
    drive_result_t res_reg;

    drive_result_t calc_result;
    drive_state_t  calc_state;
    logic          out_free;
    logic          is_last;
    logic          proc;
    logic          s_fire;

    rdfd_drive_calc u_calc (
        .state_in    (state_reg),
        .button_byte (in_byte_reg),
        .result      (calc_result),
        .state_out   (calc_state)
    );

    // handshake: a button byte needs a free result slot
    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = (pos_reg == POS_BUTTONS);
    assign proc     = in_valid_reg && (!is_last || out_free);
    assign s_ready  = !in_valid_reg || proc;
    assign s_fire   = s_valid && s_ready;

    // next state of the frame tracker
    always_comb begin
        in_valid_next = s_fire ? 1'b1 : (proc ? 1'b0 : in_valid_reg);
        pos_next      = pos_reg;
        state_next    = state_reg;
        m_valid_next  = (m_valid_reg && !m_ready) || (proc && is_last);
        if (proc) begin
            case (pos_reg)
                POS_HEADER: begin
                    if (in_byte_reg == HEADER_BYTE) begin
                        pos_next = POS_DIR;
                    end
                end
                POS_DIR: begin
                    state_next.dir_byte = in_byte_reg;
                    pos_next            = POS_STEER;
                end
                POS_STEER: begin
                    state_next.steer_byte = in_byte_reg;
                    pos_next              = POS_BUTTONS;
                end
                POS_BUTTONS: begin
                    state_next = calc_state;
                    pos_next   = POS_HEADER;
                end
                default: begin
                    pos_next = POS_HEADER;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            pos_reg              <= POS_HEADER;
            state_reg.dir_byte   <= '0;
            state_reg.steer_byte <= '0;
            state_reg.gear       <= GEAR_MIN;
            state_reg.up_prev    <= 1'b0;
            state_reg.down_prev  <= 1'b0;
            state_reg.pins       <= '0;
            m_valid_reg          <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            pos_reg      <= pos_next;
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_rx_byte;
        end
        if (proc && is_last) begin
            res_reg <= calc_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_duty_a         = res_reg.duty_a;
    assign m_duty_b         = res_reg.duty_b;
    assign m_direction_pins = res_reg.pins;
    assign m_gear_now       = res_reg.gear;

endmodule

// ===== rtl/rdfd_checker.sv =====
// Port-level checks for the drive frame decoder, bound to the top level.
// Depends on rdfd_pkg and the remote_drive_frame_decoder_unit port names.
module rdfd_checker
    import rdfd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_duty_a,
    input logic [7:0] m_duty_b,
    input logic [7:0] m_direction_pins,
    input logic [2:0] m_gear_now
);

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_duty_a) && $stable(m_duty_b)
            && $stable(m_direction_pins) && $stable(m_gear_now))
        else $error("result word changed while stalled");

    // gear stays in range
    a_gear_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gear_now >= GEAR_MIN) && (m_gear_now <= GEAR_MAX))
        else $error("gear out of range");

    // duties never exceed full scale
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_duty_a <= 8'd128) && (m_duty_b <= 8'd128))
        else $error("duty out of range");

    // a driven motor implies a fresh forward or backward pin value
    a_pins_driven: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_duty_a != 8'd0) || (m_duty_b != 8'd0))
            |-> (m_direction_pins == PINS_FORWARD) || (m_direction_pins == PINS_BACKWARD))
        else $error("motor driven with held pins");

    // unequal duties only when one motor is off
    a_one_sided: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_duty_a != m_duty_b) |-> (m_duty_a == 8'd0) || (m_duty_b == 8'd0))
        else $error("unequal nonzero duties");

endmodule

bind remote_drive_frame_decoder_unit rdfd_checker u_rdfd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_duty_a         (m_duty_a),
    .m_duty_b         (m_duty_b),
    .m_direction_pins (m_direction_pins),
    .m_gear_now       (m_gear_now)
);
